/* rtl/mept_pkg.sv */
package mept_pkg;

  localparam int DEFAULT_EXP_FRACTION_BITS = 18;
  localparam int SERIES_TERMS = 24;
  localparam int POWER_STEPS = 31;
  localparam int WHOLE_BITS = 5;

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  // exp(-1) from the truncated series: the alternating sum of floor(2^62 / k!)
  localparam logic [63:0] EXP_NEG_ONE_Q62 =
      ONE_Q62 - ONE_Q62 / 64'd1 + ONE_Q62 / 64'd2 - ONE_Q62 / 64'd6
      + ONE_Q62 / 64'd24 - ONE_Q62 / 64'd120 + ONE_Q62 / 64'd720
      - ONE_Q62 / 64'd5040 + ONE_Q62 / 64'd40320 - ONE_Q62 / 64'd362880
      + ONE_Q62 / 64'd3628800 - ONE_Q62 / 64'd39916800
      + ONE_Q62 / 64'd479001600 - ONE_Q62 / 64'd6227020800
      + ONE_Q62 / 64'd87178291200 - ONE_Q62 / 64'd1307674368000
      + ONE_Q62 / 64'd20922789888000 - ONE_Q62 / 64'd355687428096000
      + ONE_Q62 / 64'd6402373705728000 - ONE_Q62 / 64'd121645100408832000
      + ONE_Q62 / 64'd2432902008176640000;

  typedef enum logic [2:0] {
    REG_START_TIME       = 3'd0,
    REG_AMPLITUDE        = 3'd1,
    REG_RISE_CONSTANT    = 3'd2,
    REG_FALL_ONE         = 3'd3,
    REG_SECOND_WEIGHT    = 3'd4,
    REG_FALL_TWO         = 3'd5,
    REG_THIRD_WEIGHT     = 3'd6,
    REG_FALL_THREE       = 3'd7
  } reg_index_t;

  // travels with each beat through one exponential unit
  typedef struct packed {
    logic                  tag;
    logic                  zero;
    logic [WHOLE_BITS-1:0] whole;
  } exp_side_t;

endpackage

/* rtl/multi_exponential_pulse_template.sv */
// Multi-exponential pulse template generator.
// Input: a sample time is taken on every clock edge where start is high and
// busy is low; busy is high only during reset and in the cycle after it. Results come out
// in input order, each on template_value/saturated for exactly one cycle with
// done high. The receiver cannot stall the block and need not.
// Stages in order: one input stage, the exponential unit (a restoring divider
// with one quotient bit per stage, 24 series terms of six stages each, 31
// two-stage multiplies by exp(-1), one rounding stage), then eight combining
// stages.
// Throughput is one beat per clock; the four exponential units run side by
// side with no shared resource.
// Configuration: cfg_write stores cfg_data into register cfg_index at the
// clock edge. Write only while no beat is in flight.
// Reset (synchronous, rst high) restores the register defaults and drops
// every beat in flight; no stray done strobes follow.
module multi_exponential_pulse_template
  import mept_pkg::*;
#(
  parameter int EXP_FRACTION_BITS = DEFAULT_EXP_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] sample_time,
  output logic               done,
  output logic signed [31:0] template_value,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] start_time;
  logic signed [31:0] amplitude;
  logic [31:0]        rise_constant;
  logic [31:0]        fall_constant_one;
  logic signed [31:0] second_weight;
  logic [31:0]        fall_constant_two;
  logic signed [31:0] third_weight;
  logic [31:0]        fall_constant_three;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time          <= '0;
      amplitude           <= '0;
      rise_constant       <= 32'd256;
      fall_constant_one   <= 32'd256;
      second_weight       <= '0;
      fall_constant_two   <= 32'd256;
      third_weight        <= '0;
      fall_constant_three <= 32'd256;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_START_TIME:    start_time          <= cfg_data;
        REG_AMPLITUDE:     amplitude           <= cfg_data;
        REG_RISE_CONSTANT: rise_constant       <= cfg_data;
        REG_FALL_ONE:      fall_constant_one   <= cfg_data;
        REG_SECOND_WEIGHT: second_weight       <= cfg_data;
        REG_FALL_TWO:      fall_constant_two   <= cfg_data;
        REG_THIRD_WEIGHT:  third_weight        <= cfg_data;
        REG_FALL_THREE:    fall_constant_three <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // input stage
  logic        v0;
  logic        before0;
  logic [31:0] delta0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    before0 <= sample_time < start_time;
    delta0  <= 32'(sample_time - start_time);
  end

  logic        e_valid;
  logic        e_before;
  logic [30:0] e_rise;
  logic [30:0] e_one;
  logic [30:0] e_two;
  logic [30:0] e_three;

  mept_decay #(.FRAC_BITS(EXP_FRACTION_BITS)) u_rise (
    .clk(clk), .rst(rst), .in_valid(v0), .in_tag(before0), .delta(delta0),
    .tau(rise_constant), .out_valid(e_valid), .out_tag(e_before), .out_exp(e_rise)
  );

  mept_decay #(.FRAC_BITS(EXP_FRACTION_BITS)) u_fall_one (
    .clk(clk), .rst(rst), .in_valid(v0), .in_tag(before0), .delta(delta0),
    .tau(fall_constant_one), .out_valid(), .out_tag(), .out_exp(e_one)
  );

  mept_decay #(.FRAC_BITS(EXP_FRACTION_BITS)) u_fall_two (
    .clk(clk), .rst(rst), .in_valid(v0), .in_tag(before0), .delta(delta0),
    .tau(fall_constant_two), .out_valid(), .out_tag(), .out_exp(e_two)
  );

  mept_decay #(.FRAC_BITS(EXP_FRACTION_BITS)) u_fall_three (
    .clk(clk), .rst(rst), .in_valid(v0), .in_tag(before0), .delta(delta0),
    .tau(fall_constant_three), .out_valid(), .out_tag(), .out_exp(e_three)
  );

  // combining stages
  logic               c1_v, c2_v, c3_v, c4_v, c5_v, c6_v, c7_v;
  logic               c1_before, c2_before, c3_before, c4_before;
  logic               c5_before, c6_before, c7_before;
  logic signed [63:0] c1_e1s, c1_w2, c1_w3;
  logic [30:0]        c1_rise, c2_rise, c3_rise;
  logic signed [63:0] c2_s;
  logic               c3_neg, c4_neg, c5_neg, c6_neg, c7_neg;
  logic [62:0]        c3_mag;
  logic [62:0]        c4_lo;
  logic [61:0]        c4_hi;
  logic [93:0]        c5_sum;
  logic [62:0]        c5_p;
  logic [31:0]        c5_amag;
  logic [63:0]        c6_lo;
  logic [62:0]        c6_hi;
  logic [94:0]        c7_sum;
  logic [48:0]        c7_mag;

  assign c5_sum = {c4_hi, 32'd0} + 94'(c4_lo) + (94'd1 << 29);
  assign c7_sum = {c6_hi, 32'd0} + 95'(c6_lo) + (95'd1 << 45);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
      c4_v <= 1'b0;
      c5_v <= 1'b0;
      c6_v <= 1'b0;
      c7_v <= 1'b0;
    end else begin
      c1_v <= e_valid;
      c2_v <= c1_v;
      c3_v <= c2_v;
      c4_v <= c3_v;
      c5_v <= c4_v;
      c6_v <= c5_v;
      c7_v <= c6_v;
    end

    c1_before <= e_before;
    c1_e1s    <= {17'd0, e_one, 16'd0};
    c1_w2     <= second_weight * $signed({1'b0, e_two});
    c1_w3     <= third_weight * $signed({1'b0, e_three});
    c1_rise   <= 31'h4000_0000 - e_rise;

    c2_before <= c1_before;
    c2_s      <= c1_e1s + c1_w2 + c1_w3;
    c2_rise   <= c1_rise;

    c3_before <= c2_before;
    c3_neg    <= c2_s[63];
    c3_mag    <= c2_s[63] ? 63'(-c2_s) : c2_s[62:0];
    c3_rise   <= c2_rise;

    c4_before <= c3_before;
    c4_neg    <= c3_neg;
    c4_lo     <= c3_mag[31:0] * c3_rise;
    c4_hi     <= c3_mag[62:32] * c3_rise;

    c5_before <= c4_before;
    c5_neg    <= c4_neg ^ amplitude[31];
    c5_p      <= c5_sum[92:30];
    c5_amag   <= amplitude[31] ? (~amplitude + 32'd1) : amplitude;

    c6_before <= c5_before;
    c6_neg    <= c5_neg;
    c6_lo     <= c5_amag * c5_p[31:0];
    c6_hi     <= c5_amag * c5_p[62:32];

    c7_before <= c6_before;
    c7_neg    <= c6_neg;
    c7_mag    <= c7_sum[94:46];
  end

  // clip and drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c7_v;
    end
    if (c7_before || c7_mag == '0) begin
      template_value <= '0;
      saturated      <= 1'b0;
    end else if (!c7_neg) begin
      if (c7_mag > 49'h0_7FFF_FFFF) begin
        template_value <= 32'h7FFF_FFFF;
        saturated      <= 1'b1;
      end else begin
        template_value <= c7_mag[31:0];
        saturated      <= 1'b0;
      end
    end else begin
      if (c7_mag > 49'h0_8000_0000) begin
        template_value <= 32'h8000_0000;
        saturated      <= 1'b1;
      end else begin
        template_value <= ~c7_mag[31:0] + 32'd1;
        saturated      <= 1'b0;
      end
    end
  end

endmodule

/* rtl/mept_divider.sv */
module mept_divider
  import mept_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_EXP_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_tag,
  input  logic [31:0]          dividend,
  input  logic [31:0]          divisor,
  output logic                 out_valid,
  output exp_side_t            out_side,
  output logic [FRAC_BITS-1:0] out_frac
);

  localparam int QBITS = FRAC_BITS + WHOLE_BITS;

  logic [QBITS:0]            vld;
  logic                      tag  [QBITS+1];
  logic                      zero [QBITS+1];
  logic [QBITS-1:0]          quo  [QBITS+1];
  logic [31:0]               rem  [QBITS];
  logic [WHOLE_BITS-1:0]     low  [QBITS];

  // quotient of 32 or more, and a zero divisor, both flush the term to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    tag[0]  <= in_tag;
    zero[0] <= 32'(dividend >> WHOLE_BITS) >= divisor;
    quo[0]  <= '0;
    rem[0]  <= 32'(dividend >> WHOLE_BITS);
    low[0]  <= dividend[WHOLE_BITS-1:0];
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic [32:0] trial;
    logic        fits;

    // low bits of the dividend shift out first, then the zero fraction bits
    assign trial = {rem[j], low[j][WHOLE_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      tag[j+1]  <= tag[j];
      zero[j+1] <= zero[j];
      quo[j+1]  <= {quo[j][QBITS-2:0], fits};
    end

    if (j < QBITS - 1) begin : g_carry
      logic [32:0] diff;
      assign diff = trial - {1'b0, divisor};
      always_ff @(posedge clk) begin
        rem[j+1] <= fits ? diff[31:0] : trial[31:0];
        low[j+1] <= low[j] << 1;
      end
    end
  end

  assign out_valid      = vld[QBITS];
  assign out_side.tag   = tag[QBITS];
  assign out_side.zero  = zero[QBITS];
  assign out_side.whole = quo[QBITS][QBITS-1:FRAC_BITS];
  assign out_frac       = quo[QBITS][FRAC_BITS-1:0];

endmodule

/* rtl/mept_series_term.sv */
module mept_series_term
  import mept_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_EXP_FRACTION_BITS,
  parameter int K = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  exp_side_t            in_side,
  input  logic [FRAC_BITS-1:0] in_frac,
  input  logic [62:0]          in_term,
  input  logic [63:0]          in_acc,
  output logic                 out_valid,
  output exp_side_t            out_side,
  output logic [FRAC_BITS-1:0] out_frac,
  output logic [62:0]          out_term,
  output logic [63:0]          out_acc
);

  localparam int DIGIT_BITS = 16;
  localparam int DIGITS = 64 / DIGIT_BITS;
  localparam int REM_BITS = 5;
  localparam int X_BITS = REM_BITS + DIGIT_BITS;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_SHIFT:0] RECIP =
      (RECIP_SHIFT+1)'(((64'd1 << RECIP_SHIFT) + 64'(K) - 64'd1) / 64'(K));
  localparam bit SUBTRACT = (K % 2) == 1;

  logic                      v1;
  exp_side_t                 side1;
  logic [FRAC_BITS-1:0]      frac1;
  logic [63:0]               acc1;
  logic [31+FRAC_BITS:0]     pp_lo;
  logic [30+FRAC_BITS:0]     pp_hi;
  logic [62+FRAC_BITS:0]     prod;

  logic [DIGITS:0]           v;
  exp_side_t                 side [DIGITS+1];
  logic [FRAC_BITS-1:0]      frac [DIGITS+1];
  logic [63:0]               acc  [DIGITS+1];
  logic [63:0]               num  [DIGITS+1];
  logic [REM_BITS-1:0]       rem  [DIGITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    side1 <= in_side;
    frac1 <= in_frac;
    acc1  <= in_acc;
    pp_lo <= in_term[31:0] * in_frac;
    pp_hi <= in_term[62:32] * in_frac;
  end

  assign prod = {pp_hi, 32'd0} + (63+FRAC_BITS)'(pp_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= v1;
    end
    side[0] <= side1;
    frac[0] <= frac1;
    acc[0]  <= acc1;
    num[0]  <= 64'(prod >> FRAC_BITS);
    rem[0]  <= '0;
  end

  // divide by K one digit per stage; quotient digits shift in as dividend digits leave
  for (genvar j = 0; j < DIGITS; j++) begin : g_digit
    logic [X_BITS-1:0]             x;
    logic [X_BITS+RECIP_SHIFT:0]   qp;
    logic [DIGIT_BITS-1:0]         q;

    assign x  = {rem[j], num[j][63 -: DIGIT_BITS]};
    assign qp = x * RECIP;
    assign q  = qp[RECIP_SHIFT +: DIGIT_BITS];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
      side[j+1] <= side[j];
      frac[j+1] <= frac[j];
      acc[j+1]  <= acc[j];
      num[j+1]  <= {num[j][63-DIGIT_BITS:0], q};
    end

    if (j < DIGITS - 1) begin : g_rem
      logic [X_BITS-1:0] r;
      assign r = x - X_BITS'(q * K);
      always_ff @(posedge clk) begin
        rem[j+1] <= r[REM_BITS-1:0];
      end
    end
  end

  assign out_valid = v[DIGITS];
  assign out_side  = side[DIGITS];
  assign out_frac  = frac[DIGITS];
  assign out_term  = num[DIGITS][62:0];
  assign out_acc   = SUBTRACT ? acc[DIGITS] - num[DIGITS] : acc[DIGITS] + num[DIGITS];

endmodule

/* rtl/mept_power_step.sv */
module mept_power_step
  import mept_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  exp_side_t   in_side,
  input  logic [62:0] in_r,
  output logic        out_valid,
  output exp_side_t   out_side,
  output logic [62:0] out_r
);

  localparam logic [31:0] E_LO = EXP_NEG_ONE_Q62[31:0];
  localparam logic [31:0] E_HI = EXP_NEG_ONE_Q62[63:32];

  logic        va;
  exp_side_t   side_a;
  logic        apply;
  logic [62:0] r_a;
  logic [63:0] ll;
  logic [63:0] lh;
  logic [63:0] hl;
  logic [63:0] hh;
  logic [127:0] full;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    side_a <= in_side;
    apply  <= in_side.whole > WHOLE_BITS'(STEP);
    r_a    <= in_r;
    ll     <= in_r[31:0] * E_LO;
    lh     <= in_r[31:0] * E_HI;
    hl     <= in_r[62:32] * E_LO;
    hh     <= in_r[62:32] * E_HI;
  end

  assign full = {hh, 64'd0} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {64'd0, ll};

  // one more factor of exp(-1) while the step is below the whole part
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= va;
    end
    out_side <= side_a;
    out_r    <= apply ? full[124:62] : r_a;
  end

endmodule

/* rtl/mept_decay.sv */
module mept_decay
  import mept_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_EXP_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_tag,
  input  logic [31:0] delta,
  input  logic [31:0] tau,
  output logic        out_valid,
  output logic        out_tag,
  output logic [30:0] out_exp
);

  logic [SERIES_TERMS:0]  s_valid;
  exp_side_t              s_side [SERIES_TERMS+1];
  logic [FRAC_BITS-1:0]   s_frac [SERIES_TERMS+1];
  logic [62:0]            s_term [SERIES_TERMS+1];
  logic [63:0]            s_acc  [SERIES_TERMS+1];

  logic [POWER_STEPS:0]   p_valid;
  exp_side_t              p_side [POWER_STEPS+1];
  logic [62:0]            p_r    [POWER_STEPS+1];

  logic [62:0]            rounded;

  mept_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_tag    (in_tag),
    .dividend  (delta),
    .divisor   (tau),
    .out_valid (s_valid[0]),
    .out_side  (s_side[0]),
    .out_frac  (s_frac[0])
  );

  assign s_term[0] = ONE_Q62[62:0];
  assign s_acc[0]  = ONE_Q62;

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    mept_series_term #(.FRAC_BITS(FRAC_BITS), .K(k + 1)) u_term (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (s_valid[k]),
      .in_side   (s_side[k]),
      .in_frac   (s_frac[k]),
      .in_term   (s_term[k]),
      .in_acc    (s_acc[k]),
      .out_valid (s_valid[k+1]),
      .out_side  (s_side[k+1]),
      .out_frac  (s_frac[k+1]),
      .out_term  (s_term[k+1]),
      .out_acc   (s_acc[k+1])
    );
  end

  assign p_valid[0] = s_valid[SERIES_TERMS];
  assign p_side[0]  = s_side[SERIES_TERMS];
  assign p_r[0]     = s_acc[SERIES_TERMS][62:0];

  for (genvar i = 0; i < POWER_STEPS; i++) begin : g_power
    mept_power_step #(.STEP(i)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (p_valid[i]),
      .in_side   (p_side[i]),
      .in_r      (p_r[i]),
      .out_valid (p_valid[i+1]),
      .out_side  (p_side[i+1]),
      .out_r     (p_r[i+1])
    );
  end

  // round half up to the fraction width, then widen to Q30
  assign rounded = p_r[POWER_STEPS] + (63'd1 << (61 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p_valid[POWER_STEPS];
    end
    out_tag <= p_side[POWER_STEPS].tag;
    if (p_side[POWER_STEPS].zero) begin
      out_exp <= '0;
    end else begin
      out_exp <= 31'(rounded[62:62-FRAC_BITS]) << (30 - FRAC_BITS);
    end
  end

endmodule
